/* design/hermitian_rank2_update_assert.svh */
// Assertion helpers shared by the hr2u modules.
// Both expect signals named clk and rst_n in the enclosing module.
`ifndef HERMITIAN_RANK2_UPDATE_ASSERT_SVH
`define HERMITIAN_RANK2_UPDATE_ASSERT_SVH

// Same-cycle implication.
`define HR2U_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hr2u: same-cycle check failed");

// Next-cycle implication.
`define HR2U_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hr2u: next-cycle check failed");

`endif

/* design/hr2u_pkg.sv */
`timescale 1ns / 1ps

package hr2u_pkg;

    localparam int MAX_ORDER = 256;
    localparam int ADDR_W    = $clog2(MAX_ORDER);
    localparam int ORDER_W   = $clog2(MAX_ORDER + 1);
    localparam int IDX_W     = 8;
    localparam int DATA_W    = 32;
    localparam int FRAC_W    = 24;
    localparam int PROD_W    = 2 * DATA_W - FRAC_W;
    localparam int SUM_W     = PROD_W + 2;
    localparam int CFG_IDX_W = 8;

    // request kinds
    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_UPDATE = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_RE       = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_IM       = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER_TRIANGLE = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_ORDER   = CFG_IDX_W'(3);

    typedef struct packed {
        logic signed [DATA_W-1:0] re;
        logic signed [DATA_W-1:0] im;
    } cplx_t;

    // one vector store entry: x and y at the same index
    typedef struct packed {
        cplx_t x;
        cplx_t y;
    } entry_t;

    typedef struct packed {
        cplx_t              alpha;
        logic               lower_triangle;
        logic [ORDER_W-1:0] matrix_order;
    } cfg_t;

    // sideband that travels with an update through the pipeline
    typedef struct packed {
        logic signed [DATA_W-1:0] a_re;
        logic signed [DATA_W-1:0] a_im;
        logic                     diag;
        logic                     upd;
    } side_t;

    typedef struct packed {
        side_t  side;
        entry_t col_ent;
        entry_t row_ent;
    } s1_t;

    // Q8.24 product, floor of the exact product / 2^FRAC_W
    function automatic logic signed [PROD_W-1:0] qmul(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b
    );
        logic signed [2*DATA_W-1:0] p;
        p = a * b;
        return p[2*DATA_W-1:FRAC_W];
    endfunction

    // clamp to the signed DATA_W range
    function automatic logic signed [DATA_W-1:0] sat32(
        input logic signed [SUM_W-1:0] v
    );
        logic [SUM_W-DATA_W:0] hi;
        hi = v[SUM_W-1:DATA_W-1];
        if ((&hi) || (~|hi))
            return v[DATA_W-1:0];
        else if (v[SUM_W-1])
            return {1'b1, {(DATA_W-1){1'b0}}};
        else
            return {1'b0, {(DATA_W-1){1'b1}}};
    endfunction

endpackage

/* design/hr2u_in_if.sv */
`timescale 1ns / 1ps

interface hr2u_in_if;
    import hr2u_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     req_type;
    logic [IDX_W-1:0]         row_index;
    logic [IDX_W-1:0]         col_index;
    logic signed [DATA_W-1:0] x_re;
    logic signed [DATA_W-1:0] x_im;
    logic signed [DATA_W-1:0] y_re;
    logic signed [DATA_W-1:0] y_im;
    logic signed [DATA_W-1:0] a_re;
    logic signed [DATA_W-1:0] a_im;

    modport source (
        output valid, req_type, row_index, col_index,
        output x_re, x_im, y_re, y_im, a_re, a_im,
        input  ready
    );

    modport sink (
        input  valid, req_type, row_index, col_index,
        input  x_re, x_im, y_re, y_im, a_re, a_im,
        output ready
    );
endinterface

/* design/hr2u_out_if.sv */
`timescale 1ns / 1ps

interface hr2u_out_if;
    import hr2u_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] out_re;
    logic signed [DATA_W-1:0] out_im;
    logic                     was_updated;

    modport source (
        output valid, out_re, out_im, was_updated,
        input  ready
    );

    modport sink (
        input  valid, out_re, out_im, was_updated,
        output ready
    );
endinterface

/* design/hr2u_cfg_if.sv */
`timescale 1ns / 1ps

interface hr2u_cfg_if;
    import hr2u_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] reg_index;
    logic [DATA_W-1:0]    wdata;

    modport source (
        output valid, reg_index, wdata,
        input  ready
    );

    modport sink (
        input  valid, reg_index, wdata,
        output ready
    );
endinterface

/* design/hermitian_rank2_update.sv */
// Hermitian rank-2 update, one matrix element per request.
// An update gives a result from the output register; a load gives no result.
// Throughput: one request per cycle while rsp.ready is high, loads and updates
// alike; fully pipelined 7-stage datapath, two rounds of eight 32x32 multipliers.
// Reset: configuration returns to its reset values and the pipeline empties;
// the x/y vector stores are not cleared and must be loaded before use.
`timescale 1ns / 1ps
`include "hermitian_rank2_update_assert.svh"

module hermitian_rank2_update (
    input  logic       clk,
    input  logic       rst_n,
    hr2u_in_if.sink    req,
    hr2u_out_if.source rsp,
    hr2u_cfg_if.sink   cfg
);
    import hr2u_pkg::*;

    cfg_t               cfg_q;
    logic               req_acc;
    logic               is_update;
    logic               arith_ready;
    logic               s1_en;
    logic               ram_we;
    logic               ram_re;
    entry_t             wr_ent;
    entry_t             ram_rd_col;
    entry_t             ram_rd_row;
    logic [ORDER_W-1:0] order_eff;
    logic [ORDER_W-1:0] row_ext;
    logic [ORDER_W-1:0] col_ext;
    logic               in_triangle;
    logic               alpha_nz;
    side_t              s1_side_next;
    side_t              s1_side_reg;
    logic               s1_valid_reg;
    s1_t                s1_data;

    // Configuration registers.
    hr2u_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .cfg_q (cfg_q)
    );

    // Stage 1 moves when empty or when the arithmetic pipe takes its request;
    // the RAM read register is part of stage 1 and holds with it.
    assign s1_en     = !s1_valid_reg || arith_ready;
    assign req.ready = s1_en;
    assign req_acc   = req.valid && req.ready;
    assign is_update = (req.req_type == REQ_UPDATE);

    // Loads write x and y at the row index; loads beyond the store are dropped.
    assign ram_we = req_acc && (req.req_type == REQ_LOAD) &&
                    (ORDER_W'(req.row_index) < ORDER_W'(MAX_ORDER));
    assign ram_re = req_acc && is_update;

    assign wr_ent.x.re = req.x_re;
    assign wr_ent.x.im = req.x_im;
    assign wr_ent.y.re = req.y_re;
    assign wr_ent.y.im = req.y_im;

    // One store for both vectors: port A reads the column entry (temps),
    // port B the row entry (final products). A load written at one edge is
    // visible to an update read at the next.
    hr2u_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (MAX_ORDER)
    ) u_vec_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ADDR_W'(req.row_index)),
        .wdata   (wr_ent),
        .re      (ram_re),
        .raddr_a (ADDR_W'(req.col_index)),
        .raddr_b (ADDR_W'(req.row_index)),
        .rdata_a (ram_rd_col),
        .rdata_b (ram_rd_row)
    );

    // Decide up front whether the element is touched at all. Orders above
    // the store depth act as the store depth.
    always_comb
    begin
        if (cfg_q.matrix_order > ORDER_W'(MAX_ORDER))
            order_eff = ORDER_W'(MAX_ORDER);
        else
            order_eff = cfg_q.matrix_order;
        row_ext = ORDER_W'(req.row_index);
        col_ext = ORDER_W'(req.col_index);
        if (cfg_q.lower_triangle)
            in_triangle = (req.row_index >= req.col_index);
        else
            in_triangle = (req.row_index <= req.col_index);
        alpha_nz = (|cfg_q.alpha.re) || (|cfg_q.alpha.im);

        s1_side_next.a_re = req.a_re;
        s1_side_next.a_im = req.a_im;
        s1_side_next.diag = (req.row_index == req.col_index);
        s1_side_next.upd  = (row_ext < order_eff) && (col_ext < order_eff) &&
                            in_triangle && alpha_nz;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_en)
        begin
            // only updates produce a result; loads vanish here
            s1_valid_reg <= req_acc && is_update;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_en)
        begin
            s1_side_reg <= s1_side_next;
        end
    end

    assign s1_data.side    = s1_side_reg;
    assign s1_data.col_ent = ram_rd_col;
    assign s1_data.row_ent = ram_rd_row;

    // Stages 2 to 7: temps, products, saturating sums, output register.
    hr2u_arith u_arith (
        .clk      (clk),
        .rst_n    (rst_n),
        .s1_valid (s1_valid_reg),
        .s1_ready (arith_ready),
        .s1_data  (s1_data),
        .alpha    (cfg_q.alpha),
        .rsp      (rsp)
    );

    `HR2U_ASSERT_NXT(a_load_no_result, req_acc && req.req_type == REQ_LOAD, !s1_valid_reg)
    `HR2U_ASSERT_NXT(a_update_enters, req_acc && req.req_type == REQ_UPDATE, s1_valid_reg)
    `HR2U_ASSERT_NXT(a_ram_hold, s1_valid_reg && !arith_ready, $stable(ram_rd_col) && $stable(ram_rd_row))

endmodule

/* design/hr2u_ram.sv */
`timescale 1ns / 1ps

module hr2u_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a_reg <= mem_reg[raddr_a];
            rdata_b_reg <= mem_reg[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

/* design/hr2u_cfg.sv */
`timescale 1ns / 1ps

module hr2u_cfg (
    input  logic            clk,
    input  logic            rst_n,
    hr2u_cfg_if.sink        cfg,
    output hr2u_pkg::cfg_t  cfg_q
);
    import hr2u_pkg::*;

    logic signed [DATA_W-1:0] alpha_re_reg;
    logic signed [DATA_W-1:0] alpha_im_reg;
    logic                     lower_triangle_reg;
    logic [ORDER_W-1:0]       matrix_order_reg;
    logic                     wr_en;

    assign cfg.ready = 1'b1;
    assign wr_en     = cfg.valid && cfg.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_re_reg       <= '0;
            alpha_im_reg       <= '0;
            lower_triangle_reg <= 1'b1;
            matrix_order_reg   <= '0;
        end
        else if (wr_en)
        begin
            case (cfg.reg_index)
                CFG_ALPHA_RE:       alpha_re_reg       <= cfg.wdata;
                CFG_ALPHA_IM:       alpha_im_reg       <= cfg.wdata;
                CFG_LOWER_TRIANGLE: lower_triangle_reg <= cfg.wdata[0];
                CFG_MATRIX_ORDER:   matrix_order_reg   <= cfg.wdata[ORDER_W-1:0];
                default:            ; // drop writes to unknown indexes
            endcase
        end
    end

    assign cfg_q.alpha.re       = alpha_re_reg;
    assign cfg_q.alpha.im       = alpha_im_reg;
    assign cfg_q.lower_triangle = lower_triangle_reg;
    assign cfg_q.matrix_order   = matrix_order_reg;

endmodule

/* design/hr2u_arith.sv */
`timescale 1ns / 1ps
`include "hermitian_rank2_update_assert.svh"

module hr2u_arith (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s1_valid,
    output logic            s1_ready,
    input  hr2u_pkg::s1_t   s1_data,
    input  hr2u_pkg::cplx_t alpha,
    hr2u_out_if.source      rsp
);
    import hr2u_pkg::*;

    // stage valids
    logic s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic s5_valid_reg, s6_valid_reg, s7_valid_reg;
    logic en2, en3, en4, en5, en6, en7;

    // stage 2: alpha times column entries
    logic signed [PROD_W-1:0] s2_p_reg [8];
    logic signed [PROD_W-1:0] s2_p_next [8];
    cplx_t                    s2_xr_reg, s2_yr_reg;
    side_t                    s2_side_reg, s2_side_next;

    // stage 3: temp1, temp2
    cplx_t s3_t1_reg, s3_t2_reg, s3_t1_next, s3_t2_next;
    cplx_t s3_xr_reg, s3_yr_reg;
    side_t s3_side_reg;

    // stage 4: row entries times temps
    logic signed [PROD_W-1:0] s4_q_reg [8];
    logic signed [PROD_W-1:0] s4_q_next [8];
    side_t                    s4_side_reg;

    // stage 5: inner sums
    logic signed [DATA_W-1:0] s5_pra_reg, s5_prb_reg, s5_pia_reg, s5_pib_reg;
    logic signed [DATA_W-1:0] s5_pra_next, s5_prb_next, s5_pia_next, s5_pib_next;
    side_t                    s5_side_reg;

    // stage 6: outer sums
    logic signed [DATA_W-1:0] s6_pr_reg, s6_pi_reg, s6_pr_next, s6_pi_next;
    side_t                    s6_side_reg;

    // stage 7: output register
    logic signed [DATA_W-1:0] s7_re_reg, s7_im_reg, s7_re_next, s7_im_next;
    logic                     s7_upd_reg;

    // a stage takes new data when empty or when the next one moves
    assign en7      = !s7_valid_reg || rsp.ready;
    assign en6      = !s6_valid_reg || en7;
    assign en5      = !s5_valid_reg || en6;
    assign en4      = !s4_valid_reg || en5;
    assign en3      = !s3_valid_reg || en4;
    assign en2      = !s2_valid_reg || en3;
    assign s1_ready = en2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
            s7_valid_reg <= 1'b0;
        end
        else
        begin
            if (en2) s2_valid_reg <= s1_valid;
            if (en3) s3_valid_reg <= s2_valid_reg;
            if (en4) s4_valid_reg <= s3_valid_reg;
            if (en5) s5_valid_reg <= s4_valid_reg;
            if (en6) s6_valid_reg <= s5_valid_reg;
            if (en7) s7_valid_reg <= s6_valid_reg;
        end
    end

    // stage 2
    always_comb
    begin
        s2_p_next[0] = qmul(alpha.re, s1_data.col_ent.y.re);
        s2_p_next[1] = qmul(alpha.im, s1_data.col_ent.y.im);
        s2_p_next[2] = qmul(alpha.im, s1_data.col_ent.y.re);
        s2_p_next[3] = qmul(alpha.re, s1_data.col_ent.y.im);
        s2_p_next[4] = qmul(alpha.re, s1_data.col_ent.x.re);
        s2_p_next[5] = qmul(alpha.im, s1_data.col_ent.x.im);
        s2_p_next[6] = qmul(alpha.re, s1_data.col_ent.x.im);
        s2_p_next[7] = qmul(alpha.im, s1_data.col_ent.x.re);
        s2_side_next     = s1_data.side;
        // zero x and y at the column leave the element untouched
        s2_side_next.upd = s1_data.side.upd && (|s1_data.col_ent);
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            s2_p_reg    <= s2_p_next;
            s2_xr_reg   <= s1_data.row_ent.x;
            s2_yr_reg   <= s1_data.row_ent.y;
            s2_side_reg <= s2_side_next;
        end
    end

    // stage 3
    always_comb
    begin
        s3_t1_next.re = sat32(SUM_W'(s2_p_reg[0]) + SUM_W'(s2_p_reg[1]));
        s3_t1_next.im = sat32(SUM_W'(s2_p_reg[2]) - SUM_W'(s2_p_reg[3]));
        s3_t2_next.re = sat32(SUM_W'(s2_p_reg[4]) - SUM_W'(s2_p_reg[5]));
        s3_t2_next.im = sat32(-(SUM_W'(s2_p_reg[6]) + SUM_W'(s2_p_reg[7])));
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            s3_t1_reg   <= s3_t1_next;
            s3_t2_reg   <= s3_t2_next;
            s3_xr_reg   <= s2_xr_reg;
            s3_yr_reg   <= s2_yr_reg;
            s3_side_reg <= s2_side_reg;
        end
    end

    // stage 4
    always_comb
    begin
        s4_q_next[0] = qmul(s3_xr_reg.re, s3_t1_reg.re);
        s4_q_next[1] = qmul(s3_xr_reg.im, s3_t1_reg.im);
        s4_q_next[2] = qmul(s3_yr_reg.re, s3_t2_reg.re);
        s4_q_next[3] = qmul(s3_yr_reg.im, s3_t2_reg.im);
        s4_q_next[4] = qmul(s3_xr_reg.re, s3_t1_reg.im);
        s4_q_next[5] = qmul(s3_xr_reg.im, s3_t1_reg.re);
        s4_q_next[6] = qmul(s3_yr_reg.re, s3_t2_reg.im);
        s4_q_next[7] = qmul(s3_yr_reg.im, s3_t2_reg.re);
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            s4_q_reg    <= s4_q_next;
            s4_side_reg <= s3_side_reg;
        end
    end

    // stage 5
    always_comb
    begin
        s5_pra_next = sat32(SUM_W'(s4_q_reg[0]) - SUM_W'(s4_q_reg[1]));
        s5_prb_next = sat32(SUM_W'(s4_q_reg[2]) - SUM_W'(s4_q_reg[3]));
        s5_pia_next = sat32(SUM_W'(s4_q_reg[4]) + SUM_W'(s4_q_reg[5]));
        s5_pib_next = sat32(SUM_W'(s4_q_reg[6]) + SUM_W'(s4_q_reg[7]));
    end

    always_ff @(posedge clk)
    begin
        if (en5)
        begin
            s5_pra_reg  <= s5_pra_next;
            s5_prb_reg  <= s5_prb_next;
            s5_pia_reg  <= s5_pia_next;
            s5_pib_reg  <= s5_pib_next;
            s5_side_reg <= s4_side_reg;
        end
    end

    // stage 6
    assign s6_pr_next = sat32(SUM_W'(s5_pra_reg) + SUM_W'(s5_prb_reg));
    assign s6_pi_next = sat32(SUM_W'(s5_pia_reg) + SUM_W'(s5_pib_reg));

    always_ff @(posedge clk)
    begin
        if (en6)
        begin
            s6_pr_reg   <= s6_pr_next;
            s6_pi_reg   <= s6_pi_next;
            s6_side_reg <= s5_side_reg;
        end
    end

    // stage 7: add if updated, real part only on diagonal, else pass as is
    always_comb
    begin
        if (s6_side_reg.upd)
        begin
            s7_re_next = sat32(SUM_W'(s6_side_reg.a_re) + SUM_W'(s6_pr_reg));
            if (s6_side_reg.diag)
                s7_im_next = '0;
            else
                s7_im_next = sat32(SUM_W'(s6_side_reg.a_im) + SUM_W'(s6_pi_reg));
        end
        else
        begin
            s7_re_next = s6_side_reg.a_re;
            s7_im_next = s6_side_reg.a_im;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en7)
        begin
            s7_re_reg  <= s7_re_next;
            s7_im_reg  <= s7_im_next;
            s7_upd_reg <= s6_side_reg.upd;
        end
    end

    assign rsp.valid       = s7_valid_reg;
    assign rsp.out_re      = s7_re_reg;
    assign rsp.out_im      = s7_im_reg;
    assign rsp.was_updated = s7_upd_reg;

    `HR2U_ASSERT_NXT(a_s2_hold, s2_valid_reg && !en3, s2_valid_reg && $stable(s2_side_reg))
    `HR2U_ASSERT_IMP(a_full_when_blocked, !s1_ready, s2_valid_reg && s3_valid_reg && s4_valid_reg && s5_valid_reg && s6_valid_reg && s7_valid_reg && !rsp.ready)
    `HR2U_ASSERT_NXT(a_pass_through, s6_valid_reg && en7 && !s6_side_reg.upd, rsp.out_re == $past(s6_side_reg.a_re) && !rsp.was_updated)

endmodule

/* tb/sv/hr2u_element_check.sv */
`timescale 1ns / 1ps

module hr2u_element_check (
    input  logic clk,
    input  logic rst_n,
    hr2u_in_if   req,
    hr2u_out_if  rsp,
    hr2u_cfg_if  cfg,
    output int   errors,
    output int   pending
);
    import hr2u_pkg::*;

    localparam longint Q_HI = 64'sd2147483647;
    localparam longint Q_LO = -64'sd2147483648;

    typedef struct packed {
        logic signed [DATA_W-1:0] re;
        logic signed [DATA_W-1:0] im;
        logic                     upd;
    } element_t;

    logic signed [DATA_W-1:0] alpha_re;
    logic signed [DATA_W-1:0] alpha_im;
    logic                     lower_tri;
    logic [ORDER_W-1:0]       order_reg;
    cplx_t                    x_store [MAX_ORDER];
    cplx_t                    y_store [MAX_ORDER];
    element_t                 expected_elements [$];

    // Q8.24 product rounded toward minus infinity
    function automatic longint fixed_mul(input longint a, input longint b);
        return (a * b) >>> FRAC_W;
    endfunction

    function automatic longint clamp_q(input longint v);
        if (v > Q_HI)
            return Q_HI;
        if (v < Q_LO)
            return Q_LO;
        return v;
    endfunction

    function automatic element_t predict_element(
        input logic [IDX_W-1:0]         row,
        input logic [IDX_W-1:0]         col,
        input logic signed [DATA_W-1:0] a_re,
        input logic signed [DATA_W-1:0] a_im
    );
        longint   ar, ai, xr, xi, yr, yi;
        longint   t1r, t1i, t2r, t2i, p_re, p_im;
        int       span;
        logic     in_span;
        element_t res;

        res.re  = a_re;
        res.im  = a_im;
        res.upd = 1'b0;
        ar      = alpha_re;
        ai      = alpha_im;
        span    = (order_reg > MAX_ORDER) ? MAX_ORDER : int'(order_reg);
        in_span = (int'(row) < span) && (int'(col) < span) &&
                  (lower_tri ? (row >= col) : (row <= col));
        if (!in_span || (ar == 0 && ai == 0))
            return res;

        xr = $signed(x_store[col].re);
        xi = $signed(x_store[col].im);
        yr = $signed(y_store[col].re);
        yi = $signed(y_store[col].im);
        // a column with empty x and y leaves the element alone
        if (xr == 0 && xi == 0 && yr == 0 && yi == 0)
            return res;

        t1r = clamp_q(fixed_mul(ar, yr) + fixed_mul(ai, yi));
        t1i = clamp_q(fixed_mul(ai, yr) - fixed_mul(ar, yi));
        t2r = clamp_q(fixed_mul(ar, xr) - fixed_mul(ai, xi));
        t2i = clamp_q(-(fixed_mul(ar, xi) + fixed_mul(ai, xr)));

        xr = $signed(x_store[row].re);
        xi = $signed(x_store[row].im);
        yr = $signed(y_store[row].re);
        yi = $signed(y_store[row].im);
        p_re = clamp_q(clamp_q(fixed_mul(xr, t1r) - fixed_mul(xi, t1i)) +
                       clamp_q(fixed_mul(yr, t2r) - fixed_mul(yi, t2i)));
        p_im = clamp_q(clamp_q(fixed_mul(xr, t1i) + fixed_mul(xi, t1r)) +
                       clamp_q(fixed_mul(yr, t2i) + fixed_mul(yi, t2r)));

        res.re  = clamp_q(longint'(a_re) + p_re);
        res.im  = (row == col) ? '0 : clamp_q(longint'(a_im) + p_im);
        res.upd = 1'b1;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        element_t got;
        element_t want;

        if (!rst_n)
        begin
            alpha_re  = '0;
            alpha_im  = '0;
            lower_tri = 1'b1;
            order_reg = '0;
            errors    = 0;
            expected_elements.delete();
            pending   <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.reg_index)
                    CFG_ALPHA_RE:       alpha_re  = cfg.wdata;
                    CFG_ALPHA_IM:       alpha_im  = cfg.wdata;
                    CFG_LOWER_TRIANGLE: lower_tri = cfg.wdata[0];
                    CFG_MATRIX_ORDER:   order_reg = cfg.wdata[ORDER_W-1:0];
                    default: ;
                endcase
            end

            if (req.valid && req.ready)
            begin
                if (req.req_type == REQ_LOAD)
                begin
                    x_store[req.row_index] = '{re: req.x_re, im: req.x_im};
                    y_store[req.row_index] = '{re: req.y_re, im: req.y_im};
                end
                else
                    expected_elements.push_back(predict_element(
                        req.row_index, req.col_index, req.a_re, req.a_im));
            end

            if (rsp.valid && rsp.ready)
            begin
                got.re  = rsp.out_re;
                got.im  = rsp.out_im;
                got.upd = rsp.was_updated;
                if (expected_elements.size() == 0)
                begin
                    errors = errors + 1;
                    $display("%0t: unexpected element: expected none, got re=%h im=%h upd=%b",
                             $time, got.re, got.im, got.upd);
                end
                else
                begin
                    want = expected_elements.pop_front();
                    if (got.re !== want.re || got.im !== want.im || got.upd !== want.upd)
                    begin
                        errors = errors + 1;
                        $display("%0t: element mismatch: expected re=%h im=%h upd=%b,",
                                 $time, want.re, want.im, want.upd);
                        $display("%0t:   got re=%h im=%h upd=%b",
                                 $time, got.re, got.im, got.upd);
                    end
                end
            end

            pending <= expected_elements.size();
        end
    end

endmodule

/* tb/sv/hermitian_rank2_update_tb.sv */
`timescale 1ns / 1ps

module hermitian_rank2_update_tb;
    import hr2u_pkg::*;

    // margin left idle after the block has returned every update
    localparam int DRAIN_CYCLES  = 12;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 15;
    localparam int STEADY_PHASE  = 4;

    // an index past the last register, which the block must ignore
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(CFG_MATRIX_ORDER + 1);

    localparam logic signed [DATA_W-1:0] Q_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] Q_MIN  = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] Q_ONE  = 32'sh0100_0000;
    localparam logic signed [DATA_W-1:0] Q_HALF = 32'sh0080_0000;
    localparam logic signed [DATA_W-1:0] Q_ZERO = 32'sh0000_0000;

    typedef struct {
        logic                     kind;
        logic [IDX_W-1:0]         row;
        logic [IDX_W-1:0]         col;
        logic signed [DATA_W-1:0] x_re;
        logic signed [DATA_W-1:0] x_im;
        logic signed [DATA_W-1:0] y_re;
        logic signed [DATA_W-1:0] y_im;
        logic signed [DATA_W-1:0] a_re;
        logic signed [DATA_W-1:0] a_im;
    } request_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    bit   steady_flow = 1'b0;   // no idling on either side while set
    int   errors;
    int   pending;
    logic lower_now = 1'b1;     // triangle and span of the current setting,
    int   span_now  = 1;        // used to aim random updates inside it

    hr2u_in_if  req_ch ();
    hr2u_out_if rsp_ch ();
    hr2u_cfg_if cfg_ch ();

    hermitian_rank2_update i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    hr2u_element_check i_element_check (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .cfg     (cfg_ch),
        .errors  (errors),
        .pending (pending)
    );

    always #1 clk = ~clk;

    // hard stop, far beyond the slowest legal run
    initial
    begin
        #1_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // gap length: mostly none, often short, now and then long
    function automatic int idle_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        if (pick < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    // Q8.24 value: mostly small so sums stay in range, else full range or extremes
    function automatic logic signed [DATA_W-1:0] rand_fixed();
        case ($urandom_range(0, 9))
            5, 6:    return $urandom();
            7:       return Q_ZERO;
            8:       return Q_MAX;
            9:       return Q_MIN;
            default: return $urandom_range(0, 32'h0400_0000) - 32'sh0200_0000;
        endcase
    endfunction

    function automatic request_t load_req(
        input int row,
        input logic signed [DATA_W-1:0] x_re, x_im, y_re, y_im
    );
        request_t r;
        r.kind = REQ_LOAD;
        r.row  = row;
        r.col  = $urandom();
        r.x_re = x_re;
        r.x_im = x_im;
        r.y_re = y_re;
        r.y_im = y_im;
        r.a_re = $urandom();
        r.a_im = $urandom();
        return r;
    endfunction

    function automatic request_t update_req(
        input int row,
        input int col,
        input logic signed [DATA_W-1:0] a_re, a_im
    );
        request_t r;
        r.kind = REQ_UPDATE;
        r.row  = row;
        r.col  = col;
        r.x_re = $urandom();
        r.x_im = $urandom();
        r.y_re = $urandom();
        r.y_im = $urandom();
        r.a_re = a_re;
        r.a_im = a_im;
        return r;
    endfunction

    // load with random content; now and then leave x, or x and y, empty
    function automatic request_t random_load(input int row);
        case ($urandom_range(0, 9))
            0:       return load_req(row, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO);
            1:       return load_req(row, Q_ZERO, Q_ZERO, rand_fixed(), rand_fixed());
            default: return load_req(row, rand_fixed(), rand_fixed(),
                                     rand_fixed(), rand_fixed());
        endcase
    endfunction

    // mostly an element inside the active triangle, else anywhere
    function automatic request_t random_update();
        int row;
        int col;
        int tmp;
        if ($urandom_range(0, 9) < 8)
        begin
            row = $urandom_range(0, span_now - 1);
            col = $urandom_range(0, span_now - 1);
            if (lower_now ? (row < col) : (row > col))
            begin
                tmp = row;
                row = col;
                col = tmp;
            end
        end
        else
        begin
            row = $urandom_range(0, MAX_ORDER - 1);
            col = $urandom_range(0, MAX_ORDER - 1);
        end
        return update_req(row, col, $urandom(), $urandom());
    endfunction

    // Present one request and hold it until accepted. Valid stays high on
    // return so that a back-to-back request needs no second assignment.
    task automatic send_req(input request_t r);
        int gap;
        gap = steady_flow ? 0 : idle_len();
        if (gap != 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.req_type  <= r.kind;
        req_ch.row_index <= r.row;
        req_ch.col_index <= r.col;
        req_ch.x_re      <= r.x_re;
        req_ch.x_im      <= r.x_im;
        req_ch.y_re      <= r.y_re;
        req_ch.y_im      <= r.y_im;
        req_ch.a_re      <= r.a_re;
        req_ch.a_im      <= r.a_im;
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    // Drop valid, wait for every outstanding element, then let any trailing
    // load clear the pipeline so the block is idle.
    task automatic drain_requests();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // one register write; valid is left high for the next write
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.reg_index <= idx;
        cfg_ch.wdata     <= data;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
    endtask

    // Write the whole setting back to back. The unused upper bits of the
    // triangle and order words carry noise, which the block must mask.
    task automatic set_config(
        input logic signed [DATA_W-1:0] ar,
        input logic signed [DATA_W-1:0] ai,
        input logic                     lower,
        input logic [ORDER_W-1:0]       order,
        input bit                       spare
    );
        logic [DATA_W-1:0] noise;
        noise = $urandom();
        cfg_write(CFG_ALPHA_RE, ar);
        cfg_write(CFG_ALPHA_IM, ai);
        cfg_write(CFG_LOWER_TRIANGLE, {noise[DATA_W-1:1], lower});
        cfg_write(CFG_MATRIX_ORDER, {noise[DATA_W-1:ORDER_W], order});
        if (spare)
            cfg_write(CFG_SPARE, $urandom());
        cfg_ch.valid <= 1'b0;
        lower_now = lower;
        if (order == 0)
            span_now = 1;
        else if (order > MAX_ORDER)
            span_now = MAX_ORDER;
        else
            span_now = order;
    endtask

    // pick an order for a random phase: mostly small, sometimes the extremes
    function automatic logic [ORDER_W-1:0] rand_order();
        case ($urandom_range(0, 9))
            6:       return MAX_ORDER;
            7:       return $urandom_range(MAX_ORDER + 1, (1 << ORDER_W) - 1);
            8:       return '0;
            9:       return $urandom_range(17, MAX_ORDER - 1);
            default: return $urandom_range(1, 16);
        endcase
    endfunction

    // result side: hold ready high for a run, then stall at random
    initial
    begin
        int run;
        int gap;
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            rsp_ch.ready <= 1'b1;
            if (steady_flow)
                @(posedge clk);
            else
            begin
                run = $urandom_range(1, 24);
                repeat (run) @(posedge clk);
                gap = idle_len();
                if (gap != 0)
                begin
                    rsp_ch.ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    end

    // stimulus
    initial
    begin
        logic signed [DATA_W-1:0] ar;
        logic signed [DATA_W-1:0] ai;
        int                       row;

        req_ch.valid     <= 1'b0;
        req_ch.req_type  <= REQ_LOAD;
        req_ch.row_index <= '0;
        req_ch.col_index <= '0;
        req_ch.x_re      <= '0;
        req_ch.x_im      <= '0;
        req_ch.y_re      <= '0;
        req_ch.y_im      <= '0;
        req_ch.a_re      <= '0;
        req_ch.a_im      <= '0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.reg_index <= '0;
        cfg_ch.wdata     <= '0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The stores come up undefined: fill every entry before any update
        // can read it.
        for (int i = 0; i < MAX_ORDER; i++)
            send_req(random_load(i));
        drain_requests();

        // ---- directed: lower triangle, full order, alpha = 1 + 0.5i ----
        set_config(Q_ONE, Q_HALF, 1'b1, MAX_ORDER, 1'b0);
        send_req(load_req(0, Q_MAX, Q_MIN, Q_MIN, Q_MAX));
        send_req(load_req(MAX_ORDER - 1, Q_MIN, Q_MIN, Q_MAX, Q_MAX));
        send_req(load_req(7, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO));       // empty column
        send_req(load_req(8, Q_ZERO, Q_ZERO, Q_ONE, -Q_ONE));        // empty x only
        send_req(update_req(MAX_ORDER - 1, 0, Q_ZERO, Q_ZERO));
        send_req(update_req(0, MAX_ORDER - 1, Q_MAX, Q_MIN));        // upper half: pass
        send_req(update_req(MAX_ORDER - 1, MAX_ORDER - 1, Q_MIN, Q_MAX));
        send_req(update_req(9, 7, 32'sh1234_5678, 32'sh8765_4321)); // empty column
        send_req(update_req(8, 8, Q_ONE, Q_ONE));
        send_req(update_req(0, 0, Q_MAX, Q_MAX));
        drain_requests();

        // ---- directed: upper triangle, order 5, extreme alpha ----
        set_config(Q_MAX, Q_MIN, 1'b0, 5, 1'b0);
        send_req(update_req(1, 3, Q_HALF, -Q_HALF));
        send_req(update_req(3, 1, Q_HALF, -Q_HALF));                 // lower half: pass
        send_req(update_req(5, 2, Q_ONE, Q_ONE));                    // row past order
        send_req(update_req(2, 6, Q_ONE, Q_ONE));                    // column past order
        send_req(update_req(4, 4, Q_MIN, Q_MIN));
        drain_requests();

        // ---- directed: zero alpha, oversized order, write to a spare index ----
        set_config(Q_ZERO, Q_ZERO, 1'b0, 300, 1'b1);
        send_req(update_req(1, 1, Q_ONE, Q_ONE));
        send_req(update_req(2, 200, Q_MIN, Q_MAX));
        drain_requests();

        // ---- directed: imaginary alpha, order zero ----
        set_config(Q_ZERO, Q_ONE, 1'b1, 0, 1'b0);
        send_req(update_req(0, 0, Q_MAX, Q_MIN));
        drain_requests();

        // ---- directed: largest order word, acts as full size ----
        set_config(-Q_ONE, Q_ZERO, 1'b1, (1 << ORDER_W) - 1, 1'b0);
        send_req(update_req(MAX_ORDER - 1, MAX_ORDER - 2, Q_HALF, Q_HALF));
        send_req(update_req(128, 3, rand_fixed(), rand_fixed()));
        drain_requests();

        // ---- random phases: new setting each, loads and updates mixed ----
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            ar = ($urandom_range(0, 9) == 0) ? Q_ZERO : rand_fixed();
            ai = ($urandom_range(0, 9) == 0) ? Q_ZERO : rand_fixed();
            set_config(ar, ai, $urandom_range(0, 1), rand_order(), $urandom_range(0, 3) == 0);
            steady_flow = (p == STEADY_PHASE);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if ($urandom_range(0, 9) < 3)
                begin
                    // refresh entries mostly inside the active span
                    row = ($urandom_range(0, 4) == 0) ? $urandom_range(0, MAX_ORDER - 1)
                                                      : $urandom_range(0, span_now - 1);
                    send_req(random_load(row));
                end
                else
                    send_req(random_update());
            end
            drain_requests();
            steady_flow = 1'b0;
        end

        if (errors == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* sim.f */
+incdir+design
design/hr2u_pkg.sv
design/hr2u_in_if.sv
design/hr2u_out_if.sv
design/hr2u_cfg_if.sv
design/hr2u_ram.sv
design/hr2u_cfg.sv
design/hr2u_arith.sv
design/hermitian_rank2_update.sv
tb/sv/hr2u_element_check.sv
tb/sv/hermitian_rank2_update_tb.sv
